// ----- rtl/phil_pkg.sv -----
// Shared constants, types and the row-order table for the Phillips cipher block.
`timescale 1ns / 1ps
`default_nettype none

package phil_pkg;

    localparam int PERIOD        = 5;
    localparam int SQUARES_MAX   = 20;
    localparam int SQUARES_RESET = 8;

    localparam int CELL_W     = 5;
    localparam int LETTER_W   = 5;
    localparam int SQ_W       = 5;
    localparam int POS_W      = 3;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PERIOD * CELL_W;

    localparam logic [CELL_W-1:0]   LAST_CELL  = CELL_W'(26);
    localparam logic [LETTER_W-1:0] BLANK_CODE = LETTER_W'(26);
    localparam logic [IDX_W-1:0]    IDX_MAX    = IDX_W'(PERIOD - 1);
    localparam logic [POS_W-1:0]    POS_MAX    = POS_W'(PERIOD - 1);
    localparam logic [SQ_W-1:0]     SQ_MAX     = SQ_W'(SQUARES_MAX);
    localparam logic [SQ_W-1:0]     SQ_DEFAULT = SQ_W'(SQUARES_RESET);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW4    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SQUARES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd6;

    // Key square: [row][column][cell bits]; column c sits in bits 5c+4..5c of a row
    typedef logic [PERIOD-1:0][PERIOD-1:0][CELL_W-1:0] t_key_square;

    typedef struct packed {
        logic            direction;
        logic [SQ_W-1:0] square;
    } t_map_ctrl;

    // Key row that stands at row b of derived square s
    localparam logic [IDX_W-1:0] ROW_ORDER [SQUARES_MAX][PERIOD] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, '{3'd1, 3'd0, 3'd2, 3'd3, 3'd4},
        '{3'd1, 3'd2, 3'd0, 3'd3, 3'd4}, '{3'd1, 3'd2, 3'd3, 3'd0, 3'd4},
        '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0}, '{3'd2, 3'd1, 3'd3, 3'd4, 3'd0},
        '{3'd2, 3'd3, 3'd1, 3'd4, 3'd0}, '{3'd2, 3'd3, 3'd4, 3'd1, 3'd0},
        '{3'd2, 3'd3, 3'd4, 3'd0, 3'd1}, '{3'd3, 3'd2, 3'd4, 3'd0, 3'd1},
        '{3'd3, 3'd4, 3'd2, 3'd0, 3'd1}, '{3'd3, 3'd4, 3'd0, 3'd2, 3'd1},
        '{3'd3, 3'd4, 3'd0, 3'd1, 3'd2}, '{3'd4, 3'd3, 3'd0, 3'd1, 3'd2},
        '{3'd4, 3'd0, 3'd3, 3'd1, 3'd2}, '{3'd4, 3'd0, 3'd1, 3'd3, 3'd2},
        '{3'd4, 3'd0, 3'd1, 3'd2, 3'd3}, '{3'd0, 3'd4, 3'd1, 3'd2, 3'd3},
        '{3'd0, 3'd1, 3'd4, 3'd2, 3'd3}, '{3'd0, 3'd1, 3'd2, 3'd4, 3'd3}
    };

endpackage

`default_nettype wire

// ----- rtl/phillips_cipher_letter_top.sv -----
// Top level of the Phillips cipher letter block: config registers, counters, pipeline.
// Input register, mapping, result register; position and square index are registered.
// Throughput: one letter per cycle while not stalled by i_out_ready.
// Two stages (input register, result register) let a letter enter while a result waits.
// Reset (synchronous, active low): key rows cleared, num_squares 8, direction decipher,
// group position and square index zero, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module phillips_cipher_letter_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // letter input channel
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire [phil_pkg::LETTER_W-1:0]        i_letter,
    input  wire                                 i_last_letter,
    // result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [phil_pkg::LETTER_W-1:0]       o_out_letter,
    output logic                                o_out_last,
    // configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [phil_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [phil_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration
    phil_pkg::t_key_square              r_key;
    logic [phil_pkg::SQ_W-1:0]          r_num_squares;
    logic                               r_direction;

    // Group position and derived square in use
    logic [phil_pkg::POS_W-1:0]         r_pos;
    logic [phil_pkg::SQ_W-1:0]          r_square;
    logic [phil_pkg::POS_W-1:0]         n_pos;
    logic [phil_pkg::SQ_W-1:0]          n_square;

    // Stage 1: accepted letter with the square it uses
    logic                               r_s1_valid;
    logic [phil_pkg::LETTER_W-1:0]      r_s1_letter;
    logic                               r_s1_last;
    logic [phil_pkg::SQ_W-1:0]          r_s1_square;

    // Stage 2: result register
    logic                               r_out_valid;
    logic [phil_pkg::LETTER_W-1:0]      r_out_letter;
    logic                               r_out_last;

    logic                               in_xfer;
    logic                               s1_advance;
    logic [phil_pkg::SQ_W-1:0]          n_eff;
    logic [phil_pkg::SQ_W-1:0]          sq_cur;
    logic [phil_pkg::SQ_W-1:0]          sq_inc;
    logic [phil_pkg::LETTER_W-1:0]      map_letter;
    phil_pkg::t_map_ctrl                map_ctrl;

    // Writes are taken in any cycle
    assign o_cfg_ready = 1'b1;

    // Stage 1 moves on when the result register is empty or being drained
    assign s1_advance = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Clamp the square count to 1..20 and fall back to square 0 if the index ran past it
    always_comb begin
        if (r_num_squares == '0) begin
            n_eff = phil_pkg::SQ_W'(1);
        end else if (r_num_squares > phil_pkg::SQ_MAX) begin
            n_eff = phil_pkg::SQ_MAX;
        end else begin
            n_eff = r_num_squares;
        end
        sq_cur = (r_square < n_eff) ? r_square : '0;
        sq_inc = sq_cur + phil_pkg::SQ_W'(1);
    end

    // Advance the group counter per transferred letter; restart after a last letter
    always_comb begin
        n_pos    = r_pos;
        n_square = r_square;
        if (in_xfer) begin
            if (i_last_letter) begin
                n_pos    = '0;
                n_square = '0;
            end else if (r_pos >= phil_pkg::POS_MAX) begin
                n_pos    = '0;
                n_square = (sq_inc >= n_eff) ? '0 : sq_inc;
            end else begin
                n_pos    = r_pos + phil_pkg::POS_W'(1);
                n_square = sq_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key         <= '0;
            r_num_squares <= phil_pkg::SQ_DEFAULT;
            r_direction   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                phil_pkg::REG_KEY_ROW0:    r_key[0] <= i_cfg_data;
                phil_pkg::REG_KEY_ROW1:    r_key[1] <= i_cfg_data;
                phil_pkg::REG_KEY_ROW2:    r_key[2] <= i_cfg_data;
                phil_pkg::REG_KEY_ROW3:    r_key[3] <= i_cfg_data;
                phil_pkg::REG_KEY_ROW4:    r_key[4] <= i_cfg_data;
                phil_pkg::REG_NUM_SQUARES: r_num_squares <= i_cfg_data[phil_pkg::SQ_W-1:0];
                phil_pkg::REG_DIRECTION:   r_direction <= i_cfg_data[0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_square    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_square <= n_square;
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_letter <= i_letter;
            r_s1_last   <= i_last_letter;
            r_s1_square <= sq_cur;
        end
        if (s1_advance && r_s1_valid) begin
            r_out_letter <= map_letter;
            r_out_last   <= r_s1_last;
        end
    end

    assign map_ctrl.direction = r_direction;
    assign map_ctrl.square    = r_s1_square;

    phil_map u_map (
        .i_key    (r_key),
        .i_ctrl   (map_ctrl),
        .i_letter (r_s1_letter),
        .o_letter (map_letter)
    );

    assign o_out_valid  = r_out_valid;
    assign o_out_letter = r_out_letter;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/phil_map.sv -----
// Letter lookup in the key square and shift to the target cell.
`timescale 1ns / 1ps
`default_nettype none

module phil_map (
    input  wire phil_pkg::t_key_square         i_key,
    input  wire phil_pkg::t_map_ctrl           i_ctrl,
    input  wire [phil_pkg::LETTER_W-1:0]       i_letter,
    output logic [phil_pkg::LETTER_W-1:0]      o_letter
);

    logic                          found;
    logic [phil_pkg::IDX_W-1:0]    frow;
    logic [phil_pkg::IDX_W-1:0]    fcol;
    logic [phil_pkg::IDX_W-1:0]    brow;
    logic [phil_pkg::IDX_W-1:0]    nbrow;
    logic [phil_pkg::IDX_W-1:0]    ncol;
    logic [phil_pkg::IDX_W-1:0]    nkrow;
    logic [phil_pkg::CELL_W-1:0]   target;

    // Scan row-major; the last matching cell wins
    always_comb begin
        found = 1'b0;
        frow  = '0;
        fcol  = '0;
        for (int r = 0; r < phil_pkg::PERIOD; r++) begin
            for (int c = 0; c < phil_pkg::PERIOD; c++) begin
                if ((i_key[r][c] != '0) && (i_key[r][c] <= phil_pkg::LAST_CELL) &&
                    ((i_key[r][c] - phil_pkg::CELL_W'(1)) == i_letter)) begin
                    found = 1'b1;
                    frow  = phil_pkg::IDX_W'(r);
                    fcol  = phil_pkg::IDX_W'(c);
                end
            end
        end
    end

    // Place of the found key row within the current derived square
    always_comb begin
        brow = '0;
        for (int b = 0; b < phil_pkg::PERIOD; b++) begin
            if (phil_pkg::ROW_ORDER[i_ctrl.square][b] == frow) begin
                brow = phil_pkg::IDX_W'(b);
            end
        end
    end

    always_comb begin
        if (i_ctrl.direction) begin
            ncol  = (fcol == phil_pkg::IDX_MAX) ? '0 : fcol + phil_pkg::IDX_W'(1);
            nbrow = (brow == phil_pkg::IDX_MAX) ? '0 : brow + phil_pkg::IDX_W'(1);
        end else begin
            ncol  = (fcol == '0) ? phil_pkg::IDX_MAX : fcol - phil_pkg::IDX_W'(1);
            nbrow = (brow == '0) ? phil_pkg::IDX_MAX : brow - phil_pkg::IDX_W'(1);
        end
        nkrow  = phil_pkg::ROW_ORDER[i_ctrl.square][nbrow];
        target = i_key[nkrow][ncol];
        if (found && (target != '0) && (target <= phil_pkg::LAST_CELL)) begin
            o_letter = target - phil_pkg::CELL_W'(1);
        end else begin
            o_letter = phil_pkg::BLANK_CODE;
        end
    end

endmodule

`default_nettype wire
